/* design/assert_macros.svh */
// Assertion helpers for the coefficient generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define FCG_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define FCG_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define FCG_ASSERT(lbl, clk, rst, prop)
`define FCG_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* design/fcg_pkg.sv */
`default_nettype none

package fcg_pkg;

   localparam int CORDIC_STEPS = 24;

   localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;

   localparam logic signed [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
      32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
      32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
      32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
      32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
      32'sd652,       32'sd326,       32'sd163,       32'sd81
   };

   localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;

   localparam logic [2:0] REG_CENTER_X  = 3'd0;
   localparam logic [2:0] REG_CENTER_Y  = 3'd1;
   localparam logic [2:0] REG_GAIN_X    = 3'd2;
   localparam logic [2:0] REG_GAIN_Y    = 3'd3;
   localparam logic [2:0] REG_AMPLITUDE = 3'd4;

   localparam logic KIND_FORWARD  = 1'b0;
   localparam logic KIND_BACKWARD = 1'b1;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   typedef struct packed {
      logic signed [15:0] coef_imag;
      logic signed [15:0] coef_real;
   } coef_type;

endpackage

`default_nettype wire

/* design/fresnel_chirp_coefficient_gen.sv */
// Channel  Direction  Handshake                Payload
// req      in         req_tvalid/req_tready    tdata {pos_y, pos_x}, tuser kind
// rsp      out        rsp_tvalid/rsp_tready    tdata {coef_imag, coef_real}
// csr      in         csr_valid/csr_ready      csr_index, csr_data
//
// One item per cycle sustained while the output buffer has room.
// Front stages form offsets, squares, gain products and the reduced angle, 24 CORDIC stages rotate,
// then quadrant map, amplitude multiply and round/saturate, then the output register.
// Reset is synchronous and empties the pipeline; valid and configuration registers take their reset values.
// A two-entry output buffer lets the pipe take one more item while a result waits;
// req_tready comes straight from a flop and drops only when that buffer is full.
`default_nettype none

`include "assert_macros.svh"

module fresnel_chirp_coefficient_gen
   import fcg_pkg::*;
#(
   parameter int GRID_SIZE  = 1024,
   parameter int PHASE_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [11:0] pos_x, [23:12] pos_y
   input  wire logic        req_tuser,   // [0] kind

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [15:0] coef_real, [31:16] coef_imag

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   localparam logic [11:0] CENTER_RESET = 12'((GRID_SIZE - 1) / 2);
   localparam logic [31:0] PHASE_MASK   = 32'({32{1'b1}} << (32 - PHASE_BITS));

   // configuration
   logic [11:0] center_x_ff;
   logic [11:0] center_y_ff;
   logic [31:0] gain_x_ff;
   logic [31:0] gain_y_ff;
   logic [14:0] amplitude_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff  <= CENTER_RESET;
         center_y_ff  <= CENTER_RESET;
         gain_x_ff    <= '0;
         gain_y_ff    <= '0;
         amplitude_ff <= 15'h7FFF;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_CENTER_X:  center_x_ff  <= csr_data[11:0];
            REG_CENTER_Y:  center_y_ff  <= csr_data[11:0];
            REG_GAIN_X:    gain_x_ff    <= csr_data;
            REG_GAIN_Y:    gain_y_ff    <= csr_data;
            REG_AMPLITUDE: amplitude_ff <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   // pipeline advance
   logic     run;
   logic     skid_valid_ff;
   coef_type skid_data_ff;
   logic     rsp_valid_ff;
   coef_type rsp_data_ff;

   assign run        = !skid_valid_ff;
   assign req_tready = run;

   // stage 1: offsets
   logic               s1_valid_ff;
   logic               s1_kind_ff;
   logic signed [12:0] s1_dx_ff, s1_dx_in;
   logic signed [12:0] s1_dy_ff, s1_dy_in;

   assign s1_dx_in = $signed({1'b0, req_tdata[11:0]})  - $signed({1'b0, center_x_ff});
   assign s1_dy_in = $signed({1'b0, req_tdata[23:12]}) - $signed({1'b0, center_y_ff});

   // stage 2: squares
   logic               s2_valid_ff;
   logic               s2_kind_ff;
   logic [23:0]        s2_sqx_ff, s2_sqx_in;
   logic [23:0]        s2_sqy_ff, s2_sqy_in;
   logic signed [25:0] sqx_full, sqy_full;

   assign sqx_full  = s1_dx_ff * s1_dx_ff;
   assign sqy_full  = s1_dy_ff * s1_dy_ff;
   assign s2_sqx_in = sqx_full[23:0];
   assign s2_sqy_in = sqy_full[23:0];

   // stage 3: gain products, low word only
   logic        s3_valid_ff;
   logic        s3_kind_ff;
   logic [31:0] s3_px_ff, s3_px_in;
   logic [31:0] s3_py_ff, s3_py_in;
   logic [55:0] px_full, py_full;

   assign px_full  = gain_x_ff * s2_sqx_ff;
   assign py_full  = gain_y_ff * s2_sqy_ff;
   assign s3_px_in = px_full[31:0];
   assign s3_py_in = py_full[31:0];

   // stage 4 and CORDIC stages: index 0 is the reduced angle, index i+1 follows step i
   logic               cv_ff   [CORDIC_STEPS + 1];
   logic               ck_ff   [CORDIC_STEPS + 1];
   logic [1:0]         cq_ff   [CORDIC_STEPS + 1];
   logic signed [31:0] cx_ff   [CORDIC_STEPS + 1];
   logic signed [31:0] cy_ff   [CORDIC_STEPS + 1];
   logic signed [31:0] cz_ff   [CORDIC_STEPS + 1];
   logic signed [31:0] cx_in   [CORDIC_STEPS + 1];
   logic signed [31:0] cy_in   [CORDIC_STEPS + 1];
   logic signed [31:0] cz_in   [CORDIC_STEPS + 1];
   logic [31:0]        phase;
   logic [31:0]        turn;

   assign phase    = (s3_px_ff + s3_py_ff) & PHASE_MASK;
   assign turn     = phase + EIGHTH_TURN;
   assign cx_in[0] = CORDIC_X0;
   assign cy_in[0] = '0;
   assign cz_in[0] = $signed({2'b00, turn[29:0]}) - $signed(EIGHTH_TURN);

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else if (run) begin
         cv_ff[0] <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         ck_ff[0] <= s3_kind_ff;
         cq_ff[0] <= turn[31:30];
         cx_ff[0] <= cx_in[0];
         cy_ff[0] <= cy_in[0];
         cz_ff[0] <= cz_in[0];
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      logic signed [31:0] xs;
      logic signed [31:0] ys;

      assign xs = cx_ff[i] >>> i;
      assign ys = cy_ff[i] >>> i;

      always_comb begin
         if (!cz_ff[i][31]) begin
            cx_in[i + 1] = cx_ff[i] - ys;
            cy_in[i + 1] = cy_ff[i] + xs;
            cz_in[i + 1] = cz_ff[i] - ATAN_TURNS[i];
         end else begin
            cx_in[i + 1] = cx_ff[i] + ys;
            cy_in[i + 1] = cy_ff[i] - xs;
            cz_in[i + 1] = cz_ff[i] + ATAN_TURNS[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i + 1] <= 1'b0;
         end else if (run) begin
            cv_ff[i + 1] <= cv_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (run) begin
            ck_ff[i + 1] <= ck_ff[i];
            cq_ff[i + 1] <= cq_ff[i];
            cx_ff[i + 1] <= cx_in[i + 1];
            cy_ff[i + 1] <= cy_in[i + 1];
            cz_ff[i + 1] <= cz_in[i + 1];
         end
      end
   end

   // quadrant map and sign of the imaginary part
   logic               m_valid_ff;
   logic signed [32:0] m_re_ff, m_re_in;
   logic signed [32:0] m_im_ff, m_im_in;
   logic signed [32:0] fx, fy;
   logic signed [32:0] cos_v, sin_v;

   assign fx = {cx_ff[CORDIC_STEPS][31], cx_ff[CORDIC_STEPS]};
   assign fy = {cy_ff[CORDIC_STEPS][31], cy_ff[CORDIC_STEPS]};

   always_comb begin
      case (cq_ff[CORDIC_STEPS])
         QUAD_0: begin
            cos_v = fx;
            sin_v = fy;
         end
         QUAD_1: begin
            cos_v = -fy;
            sin_v = fx;
         end
         QUAD_2: begin
            cos_v = -fx;
            sin_v = -fy;
         end
         default: begin
            cos_v = fy;
            sin_v = -fx;
         end
      endcase
      m_re_in = sin_v;
      m_im_in = (ck_ff[CORDIC_STEPS] == KIND_FORWARD) ? -cos_v : cos_v;
   end

   // amplitude multiply
   logic               p_valid_ff;
   logic signed [48:0] p_re_ff, p_re_in;
   logic signed [48:0] p_im_ff, p_im_in;
   logic signed [15:0] amp_s;

   assign amp_s   = $signed({1'b0, amplitude_ff});
   assign p_re_in = m_re_ff * amp_s;
   assign p_im_in = m_im_ff * amp_s;

   // round and saturate
   logic               o_valid_ff;
   coef_type           o_data_ff, o_data_in;
   logic signed [48:0] rnd_re, rnd_im;
   logic signed [18:0] sh_re, sh_im;

   assign rnd_re = (p_re_ff + (49'sd1 <<< 29)) >>> 30;
   assign rnd_im = (p_im_ff + (49'sd1 <<< 29)) >>> 30;
   assign sh_re  = rnd_re[18:0];
   assign sh_im  = rnd_im[18:0];

   always_comb begin
      if (sh_re > 19'sd32767) begin
         o_data_in.coef_real = 16'sh7FFF;
      end else if (sh_re < -19'sd32768) begin
         o_data_in.coef_real = 16'sh8000;
      end else begin
         o_data_in.coef_real = sh_re[15:0];
      end
      if (sh_im > 19'sd32767) begin
         o_data_in.coef_imag = 16'sh7FFF;
      end else if (sh_im < -19'sd32768) begin
         o_data_in.coef_imag = 16'sh8000;
      end else begin
         o_data_in.coef_imag = sh_im[15:0];
      end
   end

   // fixed stages: valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         m_valid_ff  <= 1'b0;
         p_valid_ff  <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else if (run) begin
         s1_valid_ff <= req_tvalid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         m_valid_ff  <= cv_ff[CORDIC_STEPS];
         p_valid_ff  <= m_valid_ff;
         o_valid_ff  <= p_valid_ff;
      end
   end

   // fixed stages: payload
   always_ff @(posedge clock) begin
      if (run) begin
         s1_kind_ff <= req_tuser;
         s1_dx_ff   <= s1_dx_in;
         s1_dy_ff   <= s1_dy_in;
         s2_kind_ff <= s1_kind_ff;
         s2_sqx_ff  <= s2_sqx_in;
         s2_sqy_ff  <= s2_sqy_in;
         s3_kind_ff <= s2_kind_ff;
         s3_px_ff   <= s3_px_in;
         s3_py_ff   <= s3_py_in;
         m_re_ff    <= m_re_in;
         m_im_ff    <= m_im_in;
         p_re_ff    <= p_re_in;
         p_im_ff    <= p_im_in;
         o_data_ff  <= o_data_in;
      end
   end

   // output register with skid entry
   logic push;

   assign push = o_valid_ff && run;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff  <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_tready) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : o_data_ff;
      end else if (push) begin
         skid_data_ff <= o_data_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `FCG_ASSERT(a_skid_behind_rsp, clock, reset, skid_valid_ff |-> rsp_valid_ff)
   `FCG_ASSERT(a_skid_fill_on_stall, clock, reset,
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && !rsp_tready))
   `FCG_ASSERT(a_skid_hold, clock, reset,
      (skid_valid_ff && !rsp_tready) |=> (skid_valid_ff && $stable(skid_data_ff)))
   `FCG_ASSERT(a_empty_after_reset, clock, reset,
      $past(reset) |-> (!rsp_valid_ff && !skid_valid_ff))

endmodule

`default_nettype wire

/* test/tb_fresnel_chirp_coefficient_gen.sv */
`timescale 1ns / 1ps

module tb_fresnel_chirp_coefficient_gen;
   import fcg_pkg::*;

   localparam int GRID_SIZE  = 1024;
   localparam int PHASE_BITS = 32;
   localparam int DRAIN_WAIT = 48;
   localparam int DRAIN_LIMIT = 20000;
   localparam int PHASE_ITEMS = 305;
   localparam logic [2:0] REG_UNUSED = 3'd7;

   typedef enum int {RX_OPEN, RX_HALF, RX_MOSTLY, RX_SLOW} rx_mode_type;

   class chirp_scoreboard;
      localparam longint ARCTAN_TURNS [24] = '{
         536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
         10679838, 5340245, 2670163, 1335087, 667544, 333772,
         166886, 83443, 41722, 20861, 10430, 5215,
         2608, 1304, 652, 326, 163, 81
      };
      localparam longint ROTATOR_START = 652032874;

      int        phase_bits;
      bit [11:0] center_x;
      bit [11:0] center_y;
      bit [31:0] gain_x;
      bit [31:0] gain_y;
      bit [14:0] amplitude;
      coef_type  expected_coefs[$];
      int        errors;

      function new(int grid_size, int phase_width);
         phase_bits = phase_width;
         center_x   = 12'((grid_size - 1) / 2);
         center_y   = 12'((grid_size - 1) / 2);
         gain_x     = '0;
         gain_y     = '0;
         amplitude  = 15'h7fff;
         errors     = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] value);
         case (idx)
            REG_CENTER_X:  center_x  = value[11:0];
            REG_CENTER_Y:  center_y  = value[11:0];
            REG_GAIN_X:    gain_x    = value;
            REG_GAIN_Y:    gain_y    = value;
            REG_AMPLITUDE: amplitude = value[14:0];
            default: ;
         endcase
      endfunction

      function logic [15:0] round_scale(longint v, bit negate);
         longint prod;
         longint r;
         prod = v * longint'(amplitude);
         if (negate)
            prod = -prod;
         r = (prod + (longint'(1) <<< 29)) >>> 30;
         if (r > 32767)
            r = 32767;
         if (r < -32768)
            r = -32768;
         return r[15:0];
      endfunction

      function coef_type chirp_coef(logic kind, logic [11:0] px, logic [11:0] py);
         longint    dx, dy, x, y, z, xs, ys, c, s;
         bit [63:0] acc;
         bit [31:0] phase_mask, phase, t;
         coef_type  res;
         dx = longint'(px) - longint'(center_x);
         dy = longint'(py) - longint'(center_y);
         acc = 64'(gain_x) * 64'(dx * dx) + 64'(gain_y) * 64'(dy * dy);
         phase_mask = 32'hffff_ffff << (32 - phase_bits);
         phase = acc[31:0] & phase_mask;
         t = phase + 32'h2000_0000;
         x = ROTATOR_START;
         y = 0;
         z = longint'(t[29:0]) - longint'(32'h2000_0000);
         for (int i = 0; i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x = x - ys;
               y = y + xs;
               z = z - ARCTAN_TURNS[i];
            end else begin
               x = x + ys;
               y = y - xs;
               z = z + ARCTAN_TURNS[i];
            end
         end
         case (t[31:30])
            QUAD_0: begin c = x;  s = y;  end
            QUAD_1: begin c = -y; s = x;  end
            QUAD_2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
         endcase
         res.coef_real = round_scale(s, 1'b0);
         res.coef_imag = round_scale(c, kind == KIND_FORWARD);
         return res;
      endfunction

      function void note_request(logic kind, logic [11:0] px, logic [11:0] py);
         expected_coefs.push_back(chirp_coef(kind, px, py));
      endfunction

      task report(string msg);
         if (errors < 40)
            $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_coef(coef_type got);
         coef_type want;
         if (expected_coefs.size() == 0) begin
            report($sformatf("unexpected result %h", got));
         end else begin
            want = expected_coefs.pop_front();
            if (got.coef_real !== want.coef_real)
               report($sformatf("coef_real %h, expected %h", got.coef_real, want.coef_real));
            if (got.coef_imag !== want.coef_imag)
               report($sformatf("coef_imag %h, expected %h", got.coef_imag, want.coef_imag));
         end
      endtask
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   chirp_scoreboard board;

   fresnel_chirp_coefficient_gen #(
      .GRID_SIZE(GRID_SIZE),
      .PHASE_BITS(PHASE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("tb_fresnel_chirp_coefficient_gen: FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_coef(rsp_tdata);
   end

   // receiver: shifting stall pattern, plus a recurring long hold-off while a result waits
   initial begin
      int          cyc;
      int          hold;
      int          next_hold;
      rx_mode_type mode;
      cyc = 0;
      hold = 0;
      next_hold = 1500;
      mode = RX_OPEN;
      forever begin
         @(posedge clock);
         cyc++;
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (cyc >= next_hold && rsp_tvalid) begin
            hold = 160;
            next_hold = cyc + 2500;
            rsp_tready <= 1'b0;
         end else begin
            if (cyc % 97 == 0)
               mode = rx_mode_type'($urandom_range(0, 3));
            case (mode)
               RX_OPEN:   rsp_tready <= 1'b1;
               RX_HALF:   rsp_tready <= 1'($urandom_range(0, 1));
               RX_MOSTLY: rsp_tready <= ($urandom_range(0, 9) != 0);
               default:   rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      board.write_reg(idx, value);
   endtask

   task automatic set_regs(input logic [11:0] cx, input logic [11:0] cy,
                           input logic [31:0] gx, input logic [31:0] gy,
                           input logic [14:0] amp);
      logic [31:0] junk;
      junk = $urandom;
      write_reg(REG_CENTER_X, {junk[31:12], cx});
      write_reg(REG_UNUSED, $urandom);
      write_reg(REG_CENTER_Y, {junk[19:0], cy});
      write_reg(REG_GAIN_X, gx);
      write_reg(REG_GAIN_Y, gy);
      write_reg(REG_AMPLITUDE, {junk[16:0], amp});
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_item(input logic kind, input logic [11:0] px, input logic [11:0] py);
      req_tvalid <= 1'b1;
      req_tdata  <= {py, px};
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      board.note_request(kind, px, py);
   endtask

   task automatic wait_drain();
      int waited;
      waited = 0;
      while (board.expected_coefs.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic random_phase(input int count);
      int          left;
      int          burst;
      int          gap;
      logic [11:0] px;
      logic [11:0] py;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 40);
         if (burst > left)
            burst = left;
         left -= burst;
         repeat (burst) begin
            if ($urandom_range(0, 3) == 0) begin
               px = board.center_x + 12'($urandom_range(0, 80)) - 12'd40;
               py = board.center_y + 12'($urandom_range(0, 80)) - 12'd40;
            end else begin
               px = 12'($urandom);
               py = 12'($urandom);
            end
            send_item(1'($urandom), px, py);
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0 && left > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      board = new(GRID_SIZE, PHASE_BITS);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset registers: zero gains, full amplitude
      send_item(KIND_FORWARD, 12'd0, 12'd0);
      send_item(KIND_BACKWARD, 12'd4095, 12'd4095);
      send_item(KIND_FORWARD, 12'd511, 12'd511);
      send_item(KIND_BACKWARD, 12'd0, 12'd4095);
      req_tvalid <= 1'b0;
      wait_drain();

      // gains only, centers still at reset: walk through all quadrants
      write_reg(REG_GAIN_X, 32'h0100_0000);
      write_reg(REG_GAIN_Y, 32'h0040_0000);
      csr_valid <= 1'b0;
      @(posedge clock);
      send_item(KIND_FORWARD, 12'd511, 12'd511);
      send_item(KIND_BACKWARD, 12'd511, 12'd511);
      send_item(KIND_FORWARD, 12'd519, 12'd511);
      send_item(KIND_BACKWARD, 12'd522, 12'd511);
      send_item(KIND_FORWARD, 12'd524, 12'd511);
      send_item(KIND_BACKWARD, 12'd526, 12'd511);
      send_item(KIND_FORWARD, 12'd511, 12'd527);
      send_item(KIND_BACKWARD, 12'd511, 12'd495);
      send_item(KIND_FORWARD, 12'd4095, 12'd0);
      send_item(KIND_BACKWARD, 12'd0, 12'd0);
      send_item(KIND_FORWARD, 12'd4095, 12'd4095);
      req_tvalid <= 1'b0;
      wait_drain();

      set_regs(12'd512, 12'd512, $urandom, $urandom, 15'h7fff);
      random_phase(PHASE_ITEMS);
      wait_drain();

      set_regs(12'd0, 12'd4095, 32'hffff_ffff, 32'h0, 15'h0);
      random_phase(PHASE_ITEMS);
      wait_drain();

      set_regs(12'd4095, 12'd0, 32'h0, 32'hffff_ffff, 15'd1);
      random_phase(PHASE_ITEMS);
      wait_drain();

      set_regs(12'($urandom), 12'($urandom), $urandom, $urandom, 15'($urandom));
      random_phase(PHASE_ITEMS);
      wait_drain();

      set_regs(12'($urandom), 12'($urandom), 32'($urandom_range(0, 1048575)),
               32'($urandom_range(0, 1048575)), 15'($urandom));
      random_phase(PHASE_ITEMS);
      wait_drain();

      set_regs(12'd2047, 12'd2047, $urandom, $urandom, 15'h7fff);
      random_phase(PHASE_ITEMS);
      wait_drain();

      if (board.expected_coefs.size() != 0)
         board.report($sformatf("%0d results never arrived", board.expected_coefs.size()));
      if (board.errors == 0) begin
         $display("tb_fresnel_chirp_coefficient_gen: PASS");
      end else begin
         $display("tb_fresnel_chirp_coefficient_gen: FAIL");
      end
      $finish;
   end

endmodule
